/* design/hce_pkg.sv */
// ----------------------------------------------------------------------------
// hce_pkg
// Shared types and constants for the Hill cipher encrypter: register
// indexes, letter codes, the block record passed from front to back.
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int KeyDimDefault = 3;
  localparam int QueueDepth    = 2;

  localparam logic [7:0]  LetterA       = 8'd65;
  localparam logic [7:0]  LetterZ       = 8'd90;
  localparam logic [6:0]  CipherBase    = 7'd65;
  localparam logic [4:0]  PadLetter     = 5'd23;
  localparam logic [11:0] Alpha         = 12'd26;
  // floor(x * RecipMul / 2^16) == floor(x / 26) for every row sum below 2^12
  localparam logic [11:0] RecipMul      = 12'd2521;
  localparam int          RecipShift    = 16;
  localparam logic [1:0]  BlockSizeRst  = 2'd3;
  localparam logic [1:0]  BlockSizeTwo  = 2'd2;

  typedef enum logic [1:0] {
    REG_BLOCK_SIZE = 2'd0,
    REG_KEY_ROW0   = 2'd1,
    REG_KEY_ROW1   = 2'd2,
    REG_KEY_ROW2   = 2'd3
  } reg_idx_e;

  typedef logic [4:0] letter_t;
  typedef logic [2:0][14:0] key_rows_t;

  typedef struct packed {
    letter_t [2:0] letters;
    logic          three;
    logic          done;
  } block_t;

endpackage

/* design/hce_front.sv */
// ----------------------------------------------------------------------------
// hce_front
// Collects letters into the current block, drops other bytes, pads with X on
// a flush and hands each finished block to the queue.
// ----------------------------------------------------------------------------
module hce_front #(
  parameter int KEY_DIM = hce_pkg::KeyDimDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_code_i,
  input  logic            end_of_message_i,
  input  logic [1:0]      block_size_i,
  output logic            blk_push_o,
  output hce_pkg::block_t blk_o
);

  logic [1:0]       fill_q, fill_d;
  hce_pkg::letter_t [2:0] buf_q, buf_d, pad_w;
  hce_pkg::letter_t letter;
  logic             is_letter, three, complete, flush;
  logic [1:0]       fill_inc, fill_lim, fill_after;

  assign is_letter  = (char_code_i >= hce_pkg::LetterA) && (char_code_i <= hce_pkg::LetterZ);
  assign letter     = 5'(char_code_i - hce_pkg::LetterA);
  assign three      = !((block_size_i == hce_pkg::BlockSizeTwo) || (KEY_DIM == 2));
  assign fill_lim   = three ? 2'd3 : 2'd2;
  assign fill_inc   = fill_q + 2'd1;
  assign fill_after = is_letter ? fill_inc : fill_q;
  assign complete   = is_letter && ((fill_inc == 2'd0) || (fill_inc >= fill_lim));
  assign flush      = !complete && end_of_message_i && (fill_after != 2'd0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      buf_d[i] = (is_letter && (fill_q == 2'(i))) ? letter : buf_q[i];
      pad_w[i] = (flush && (2'(i) >= fill_after)) ? hce_pkg::PadLetter : buf_d[i];
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (accept_i) begin
      fill_d = (complete || flush) ? 2'd0 : fill_after;
    end
  end

  assign blk_push_o    = accept_i && (complete || flush);
  assign blk_o.letters = pad_w;
  assign blk_o.three   = three;
  assign blk_o.done    = end_of_message_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      buf_q <= buf_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a block is always emitted before the count could wrap
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3) else $error("fill count reached three");

  a_push_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_push_o |=> fill_q == 2'd0) else $error("fill count kept after block push");
`endif

endmodule

/* design/hce_fifo.sv */
// ----------------------------------------------------------------------------
// hce_fifo
// Short block queue between the letter collector and the row engine.
// ----------------------------------------------------------------------------
module hce_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hce_pkg::block_t data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output hce_pkg::block_t data_o
);

  localparam int PtrW = $clog2(hce_pkg::QueueDepth);
  localparam int CntW = $clog2(hce_pkg::QueueDepth + 1);

  hce_pkg::block_t mem_q [hce_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(hce_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(hce_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(hce_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("block queue overflow");
`endif

endmodule

/* design/hce_back.sv */
// ----------------------------------------------------------------------------
// hce_back
// Row engine: one key row per cycle while not stalled, dotted with the block,
// then reduced mod 26 into the result register.
// ----------------------------------------------------------------------------
module hce_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               blk_valid_i,
  input  hce_pkg::block_t    blk_i,
  input  hce_pkg::key_rows_t key_rows_i,
  input  logic               pop_i,
  output logic               blk_pop_o,
  output logic               empty_o,
  output logic [6:0]         cipher_char_o,
  output logic               last_in_block_o,
  output logic               message_done_o
);

  logic [1:0]  row_q, row_d, last_row;
  logic        is_last, issue, out_ready, s1_ready;
  logic [14:0] key_row;
  logic [9:0]  prod0, prod1, prod2;
  logic [11:0] sum;

  logic        s1_v_q, s1_last_q, s1_done_q;
  logic [11:0] s1_sum_q;

  logic [23:0] quot_wide;
  logic [6:0]  quot;
  logic [4:0]  rem;

  logic        out_v_q, out_last_q, out_done_q;
  logic [6:0]  out_char_q;

  assign last_row  = blk_i.three ? 2'd2 : 2'd1;
  assign is_last   = (row_q == last_row);
  assign out_ready = !out_v_q || pop_i;
  assign s1_ready  = !s1_v_q || out_ready;
  assign issue     = blk_valid_i && s1_ready;
  assign blk_pop_o = issue && is_last;

  always_comb begin
    case (row_q)
      2'd0:    key_row = key_rows_i[0];
      2'd1:    key_row = key_rows_i[1];
      2'd2:    key_row = key_rows_i[2];
      default: key_row = '0;
    endcase
  end

  assign prod0 = key_row[4:0]   * blk_i.letters[0];
  assign prod1 = key_row[9:5]   * blk_i.letters[1];
  assign prod2 = key_row[14:10] * blk_i.letters[2];
  assign sum   = 12'(prod0) + 12'(prod1) + (blk_i.three ? 12'(prod2) : 12'd0);

  assign row_d = issue ? (is_last ? 2'd0 : row_q + 2'd1) : row_q;

  assign quot_wide = 24'(s1_sum_q) * 24'(hce_pkg::RecipMul);
  assign quot      = 7'(quot_wide >> hce_pkg::RecipShift);
  assign rem       = 5'(s1_sum_q - 12'(quot) * hce_pkg::Alpha);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= 2'd0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      row_q <= row_d;
      if (s1_ready) begin
        s1_v_q <= issue;
      end
      if (out_ready) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_sum_q  <= sum;
      s1_last_q <= is_last;
      s1_done_q <= is_last && blk_i.done;
    end
    if (out_ready && s1_v_q) begin
      out_char_q <= 7'(rem) + hce_pkg::CipherBase;
      out_last_q <= s1_last_q;
      out_done_q <= s1_done_q;
    end
  end

  assign empty_o         = !out_v_q;
  assign cipher_char_o   = out_char_q;
  assign last_in_block_o = out_last_q;
  assign message_done_o  = out_done_q;

`ifndef NO_ASSERTIONS
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != 2'd3) else $error("row counter out of range");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_char_q >= hce_pkg::CipherBase) && (out_char_q <= 7'd90))
    else $error("cipher letter out of range");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_done_q |-> out_last_q) else $error("message end not on block end");
`endif

endmodule

/* design/hill_cipher_encrypt.sv */
// Path: a byte that completes or flushes a block enters the block queue; its
//   first letter passes the row and result registers to the result ports;
//   the block's letters follow one per cycle while the output is popped.
// Throughput: one byte per cycle unless full; a two-entry block queue absorbs
//   flush bursts; the row engine retires one letter per cycle unless stalled.
// Reset: rst_ni clears the letter count, queue and output; block size
//   returns to 3 and all key rows to zero.
// ----------------------------------------------------------------------------
// hill_cipher_encrypt
// Hill cipher encrypter over A..Z with a 2x2 or 3x3 key, queue interfaces on
// both sides and a register write port for block size and key rows.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt #(
  parameter int KEY_DIM = hce_pkg::KeyDimDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  cipher_char_o,
  output logic        last_in_block_o,
  output logic        message_done_o
);

  logic               accept, blk_push, blk_pop, blk_valid;
  hce_pkg::block_t    blk_in, blk_out;
  logic [1:0]         block_size_q;
  hce_pkg::key_rows_t key_rows_q;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= hce_pkg::BlockSizeRst;
      key_rows_q   <= '0;
    end else if (cfg_valid_i) begin
      case (hce_pkg::reg_idx_e'(cfg_index_i))
        hce_pkg::REG_BLOCK_SIZE: block_size_q  <= cfg_data_i[1:0];
        hce_pkg::REG_KEY_ROW0:   key_rows_q[0] <= cfg_data_i;
        hce_pkg::REG_KEY_ROW1:   key_rows_q[1] <= cfg_data_i;
        hce_pkg::REG_KEY_ROW2:   key_rows_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hce_front #(
    .KEY_DIM (KEY_DIM)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .char_code_i      (char_code_i),
    .end_of_message_i (end_of_message_i),
    .block_size_i     (block_size_q),
    .blk_push_o       (blk_push),
    .blk_o            (blk_in)
  );

  hce_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (blk_push),
    .data_i  (blk_in),
    .pop_i   (blk_pop),
    .full_o  (full),
    .valid_o (blk_valid),
    .data_o  (blk_out)
  );

  hce_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .blk_valid_i     (blk_valid),
    .blk_i           (blk_out),
    .key_rows_i      (key_rows_q),
    .pop_i           (pop),
    .blk_pop_o       (blk_pop),
    .empty_o         (empty),
    .cipher_char_o   (cipher_char_o),
    .last_in_block_o (last_in_block_o),
    .message_done_o  (message_done_o)
  );

endmodule
